[hw/rtl/wsc_pkg.sv]
// Shared types, constants and tables of the waypoint steering controller.
package wsc_pkg;

  localparam int OP_W      = 3;
  localparam int LAT_W     = 31;
  localparam int LON_W     = 32;
  localparam int YAW_W     = 16;
  localparam int STEER_W   = 8;
  localparam int SPEED_W   = 7;
  localparam int LEFT_W    = 4;
  localparam int DIST_W    = 29;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int POS_W     = LAT_W + LON_W;

  localparam int WAYPOINT_DEPTH_DEF = 10;
  localparam int CRUMB_DEPTH_DEF    = 10;

  localparam logic [OP_W-1:0] OP_CTRL   = 3'd0;
  localparam logic [OP_W-1:0] OP_CRUMB  = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd2;
  localparam logic [OP_W-1:0] OP_GO     = 3'd3;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;
  localparam logic [OP_W-1:0] OP_FS_ON  = 3'd6;
  localparam logic [OP_W-1:0] OP_FS_OFF = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_HOME_LAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOME_LON = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FENCE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAD_AUTO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RAD_FS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING  = 3'd6;

  localparam logic signed [30:0] HOME_LAT_RST = 31'sd380000000;
  localparam logic signed [31:0] HOME_LON_RST = -32'sd1110000000;
  localparam logic [29:0]        FENCE_RST    = 30'd30000000;
  localparam logic [7:0]         GAIN_RST     = 8'd48;
  localparam logic [16:0]        RAD_AUTO_RST = 17'd300;
  localparam logic [16:0]        RAD_FS_RST   = 17'd200;
  localparam logic [19:0]        SPACING_RST  = 20'd1500;
  localparam logic [DIST_W-1:0]  DIST_RST     = 29'd1000;
  localparam logic [DIST_W-1:0]  DIST_MAX     = 29'd536870911;

  localparam logic signed [24:0] HALF_TURN_Z  = 25'sd4608000;
  localparam logic [15:0]        FULL_CDEG    = 16'd36000;

  typedef struct packed {
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
  } pos_t;

  function automatic logic [20:0] atan_lut(input logic [3:0] i);
    logic [20:0] v;
    case (i)
      4'd0:    v = 21'd1152000;
      4'd1:    v = 21'd680065;
      4'd2:    v = 21'd359328;
      4'd3:    v = 21'd182400;
      4'd4:    v = 21'd91554;
      4'd5:    v = 21'd45822;
      4'd6:    v = 21'd22916;
      4'd7:    v = 21'd11459;
      4'd8:    v = 21'd5730;
      4'd9:    v = 21'd2865;
      4'd10:   v = 21'd1432;
      4'd11:   v = 21'd716;
      4'd12:   v = 21'd358;
      4'd13:   v = 21'd179;
      4'd14:   v = 21'd90;
      default: v = 21'd45;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/wsc_if.sv]
// Item and result channel interfaces of the waypoint steering controller.
interface wsc_in_if;
  import wsc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic signed [LAT_W-1:0] lat;
  logic signed [LON_W-1:0] lon;
  logic [YAW_W-1:0]        yaw_cdeg;
  logic                    fix_new;
  modport source (output valid, op, lat, lon, yaw_cdeg, fix_new, input ready);
  modport sink (input valid, op, lat, lon, yaw_cdeg, fix_new, output ready);
endinterface

interface wsc_out_if;
  import wsc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [STEER_W-1:0] steer;
  logic [SPEED_W-1:0]        speed;
  logic                      nav_mode;
  logic [LEFT_W-1:0]         waypoints_left;
  logic [LEFT_W-1:0]         crumbs_left;
  logic [DIST_W-1:0]         distance_cm;
  modport source (output valid, steer, speed, nav_mode, waypoints_left, crumbs_left,
                  distance_cm, input ready);
  modport sink (input valid, steer, speed, nav_mode, waypoints_left, crumbs_left,
                distance_cm, output ready);
endinterface

[hw/rtl/wsc_ram.sv]
// Generic single write port RAM with registered read.
module wsc_ram #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

[hw/rtl/wsc_dist.sv]
// Distance unit: squares, iterative integer square root, scale by 1.11.
module wsc_dist (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [31:0]              dlat_i,
  input  logic signed [32:0]              dlon_i,
  output logic                            vld_o,
  output logic [wsc_pkg::DIST_W-1:0]      dist_o
);
  import wsc_pkg::*;

  localparam logic [2:0] D_IDLE = 3'd0;
  localparam logic [2:0] D_SQ1  = 3'd1;
  localparam logic [2:0] D_SQ2  = 3'd2;
  localparam logic [2:0] D_ROOT = 3'd3;
  localparam logic [2:0] D_MUL  = 3'd4;
  localparam logic [2:0] D_DIV  = 3'd5;
  localparam logic [2:0] D_END  = 3'd6;
  localparam logic [2:0] D_ADD  = 3'd7;

  // floor(y/25) = floor(y * (2^32 + RECIP_LO) / 2^37) for any 32-bit y
  localparam logic [30:0] RECIP_LO = 31'd1202590843;

  logic [2:0]  state_q;
  logic [29:0] alat_q, alon_q;
  logic        sat_q, vld_q;
  logic [59:0] sq_q;
  logic [60:0] n_q, r_q, b_q;
  logic [5:0]  cnt_q;
  logic [30:0] root_q;
  logic [31:0] y_q;
  logic [62:0] pr_q;
  logic [27:0] quo_q;
  logic [DIST_W-1:0] dist_q;

  logic signed [33:0] slat, slon, mlat, mlon;
  logic [59:0] lsq;
  logic [61:0] rt;
  logic        rge;
  logic [64:0] psum;
  logic [35:0] dsum;

  always_comb begin
    slat = 34'(dlat_i);
    slon = 34'(dlon_i);
    mlat = slat < 0 ? -slat : slat;
    mlon = slon < 0 ? -slon : slon;
    lsq  = alon_q * alon_q;
    rt   = {1'b0, r_q} + {1'b0, b_q};
    rge  = {1'b0, n_q} >= rt;
    psum = {1'b0, y_q, 32'd0} + 65'(pr_q);
    dsum = 36'(root_q) + 36'(quo_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      vld_q   <= 1'b0;
    end else begin
      case (state_q)
        D_IDLE: begin
          if (start_i) begin
            vld_q   <= 1'b0;
            state_q <= D_SQ1;
          end
        end
        D_SQ1:  state_q <= D_SQ2;
        D_SQ2:  state_q <= D_ROOT;
        D_ROOT: begin
          if (cnt_q == 6'd30) begin
            state_q <= D_MUL;
          end
        end
        D_MUL:  state_q <= D_DIV;
        D_DIV:  state_q <= D_ADD;
        D_ADD:  state_q <= D_END;
        D_END: begin
          vld_q   <= 1'b1;
          state_q <= D_IDLE;
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      D_IDLE: begin
        alat_q <= mlat[29:0];
        alon_q <= mlon[29:0];
        sat_q  <= (|mlat[33:30]) || (|mlon[33:30]);
      end
      D_SQ1: sq_q <= alat_q * alat_q;
      D_SQ2: begin
        n_q   <= 61'(sq_q) + 61'(lsq);
        r_q   <= '0;
        b_q   <= 61'(1) << 60;
        cnt_q <= '0;
      end
      D_ROOT: begin
        if (rge) begin
          n_q <= n_q - rt[60:0];
          r_q <= (r_q >> 1) + b_q;
        end else begin
          r_q <= r_q >> 1;
        end
        b_q   <= b_q >> 2;
        cnt_q <= cnt_q + 6'd1;
      end
      D_MUL: begin
        root_q <= r_q[30:0];
        y_q    <= 32'(((35'(r_q[30:0]) << 3) + (35'(r_q[30:0]) << 1) +
                       35'(r_q[30:0])) >> 2);
      end
      D_DIV: pr_q <= y_q * RECIP_LO;
      D_ADD: quo_q <= psum[64:37];
      D_END: dist_q <= (sat_q || dsum > 36'(DIST_MAX)) ? DIST_MAX : dsum[DIST_W-1:0];
      default: ;
    endcase
  end

  assign vld_o  = vld_q;
  assign dist_o = dist_q;
endmodule

[hw/rtl/wsc_cordic.sv]
// Bearing unit: 16-step vectoring CORDIC, result in centidegrees.
module wsc_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] dlat_i,
  input  logic signed [32:0] dlon_i,
  output logic               vld_o,
  output logic [15:0]        heading_o
);
  import wsc_pkg::*;

  logic               busy_q, fin_q, vld_q, zero_q;
  logic [3:0]         i_q;
  logic signed [35:0] x_q, y_q, xs, ys, x0, y0;
  logic signed [24:0] z_q, ang, z0, zr;
  logic signed [16:0] c;
  logic [15:0]        heading_q;

  always_comb begin
    xs  = x_q >>> i_q;
    ys  = y_q >>> i_q;
    ang = 25'(atan_lut(i_q));
    x0  = 36'(dlat_i);
    y0  = 36'(dlon_i);
    z0  = '0;
    if (dlat_i < 0) begin
      z0 = (dlon_i >= 0) ? HALF_TURN_Z : -HALF_TURN_Z;
      x0 = -x0;
      y0 = -y0;
    end
    zr = (z_q + 25'sd128) >>> 8;
    c  = zr[16:0];
    if (c < 0) begin
      c = c + 17'sd36000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      vld_q  <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      vld_q  <= 1'b0;
    end else if (busy_q) begin
      if (i_q == 4'd15) begin
        busy_q <= 1'b0;
        fin_q  <= 1'b1;
      end
    end else if (fin_q) begin
      fin_q <= 1'b0;
      vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x0;
      y_q    <= y0;
      z_q    <= z0;
      i_q    <= '0;
      zero_q <= (dlat_i == 0) && (dlon_i == 0);
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + ang;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - ang;
      end
      i_q <= i_q + 4'd1;
    end else if (fin_q) begin
      heading_q <= zero_q ? 16'd0 : c[15:0];
    end
  end

  assign vld_o     = vld_q;
  assign heading_o = heading_q;
endmodule

[hw/rtl/waypoint_steering_controller_core.sv]
// Waypoint steering controller top level: sequencer, list pointers, steering law.
//
//   channel   dir   signals                                         transfer when
//   cfg       in    cfg_we_i, cfg_idx_i, cfg_wdata_i                cfg_we_i high
//   in_i      in    op, lat, lon, yaw_cdeg, fix_new                 valid && ready
//   out_o     out   steer, speed, nav_mode, *_left, distance_cm     valid && ready
//
// Ticks that aim at a target wait on the 31-step square root in the distance unit;
// the CORDIC runs alongside. Ticks without a fresh fix skip both units.
// Lists live in two RAMs as a circular queue and a circular stack; no clear pass.
// A result waits in the output register; input is taken again once the sequencer idles.
module waypoint_steering_controller_core #(
  parameter int WAYPOINT_DEPTH = wsc_pkg::WAYPOINT_DEPTH_DEF,
  parameter int CRUMB_DEPTH    = wsc_pkg::CRUMB_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wsc_pkg::CFG_W-1:0]      cfg_wdata_i,
  wsc_in_if.sink                         in_i,
  wsc_out_if.source                      out_o
);
  import wsc_pkg::*;

  localparam int WA = $clog2(WAYPOINT_DEPTH);
  localparam int CA = $clog2(CRUMB_DEPTH);
  localparam int WC = $clog2(WAYPOINT_DEPTH + 1);
  localparam int CC = $clog2(CRUMB_DEPTH + 1);
  localparam logic [WA-1:0] WP_LAST = WA'(WAYPOINT_DEPTH - 1);
  localparam logic [CA-1:0] CR_LAST = CA'(CRUMB_DEPTH - 1);
  localparam logic [WC-1:0] WP_FULL = WC'(WAYPOINT_DEPTH);
  localparam logic [CC-1:0] CR_FULL = CC'(CRUMB_DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_ADDCK = 4'd2;
  localparam logic [3:0] S_LOAD  = 4'd3;
  localparam logic [3:0] S_START = 4'd4;
  localparam logic [3:0] S_CALC  = 4'd5;
  localparam logic [3:0] S_FIN   = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic signed [LAT_W-1:0] home_lat_q;
  logic signed [LON_W-1:0] home_lon_q;
  logic [29:0] fence_q;
  logic [7:0]  gain_q;
  logic [16:0] rad_auto_q, rad_fs_q;
  logic [19:0] spacing_q;

  logic [3:0]  state_q, state_d;
  logic [OP_W-1:0]         op_q;
  logic signed [LAT_W-1:0] lat_q;
  logic signed [LON_W-1:0] lon_q;
  logic [YAW_W-1:0]        yaw_q;
  logic                    fix_q;

  logic [WA-1:0] hd_q, hd_d;
  logic [WC-1:0] wcnt_q, wcnt_d;
  logic [CA-1:0] top_q, top_d;
  logic [CC-1:0] ccnt_q, ccnt_d;
  logic auto_q, auto_d, fs_q, fs_d;
  logic [15:0] head_q, head_d;
  logic [DIST_W-1:0] ldist_q, ldist_d;
  logic signed [31:0] dlat_q, dlat_d;
  logic signed [32:0] dlon_q, dlon_d;
  logic signed [15:0] err_q, err_d;
  logic signed [24:0] prod_q;
  logic [SPEED_W-1:0] spd_q;

  logic out_vld_q, out_vld_d, out_load;
  logic signed [STEER_W-1:0] steer_q, steer_w;
  logic [SPEED_W-1:0] speed_q;
  logic nav_q;
  logic [LEFT_W-1:0] wl_q, cl_q;
  logic [DIST_W-1:0] dist_out_q;

  logic wp_we, cr_we;
  logic [WA-1:0] wp_waddr, wp_raddr, wp_tail, wp_prev;
  logic [CA-1:0] top_inc, top_dec;
  pos_t wp_rdata, cr_rdata, tgt, cur;
  logic [POS_W-1:0] wp_rraw, cr_rraw;

  logic signed [33:0] fdlat, fdlon;
  logic [33:0] falat, falon;
  logic in_fence, fresh, start;
  logic [WA+1:0] tsum, psum;
  logic dist_vld, cor_vld;
  logic [DIST_W-1:0] dist_res;
  logic [15:0] heading;

  logic [15:0] yawv;
  logic signed [17:0] ediff;
  logic [15:0] aerr;
  logic [25:0] sprod;
  logic [9:0]  sq;
  logic [23:0] aprod;
  logic [22:0] tprod;
  logic [6:0]  tq, tmag;

  assign cur = '{lat: lat_q, lon: lon_q};
  assign wp_rdata = pos_t'(wp_rraw);
  assign cr_rdata = pos_t'(cr_rraw);

  always_comb begin
    fdlat = 34'(lat_q) - 34'(home_lat_q);
    fdlon = 34'(lon_q) - 34'(home_lon_q);
    falat = fdlat < 0 ? 34'(-fdlat) : 34'(fdlat);
    falon = fdlon < 0 ? 34'(-fdlon) : 34'(fdlon);
    in_fence = (falat < 34'(fence_q)) && (falon < 34'(fence_q));
    fresh = fix_q && in_fence;
    tsum = (WA+2)'(hd_q) + (WA+2)'(wcnt_q);
    wp_tail = (tsum >= (WA+2)'(WAYPOINT_DEPTH)) ?
              WA'(tsum - (WA+2)'(WAYPOINT_DEPTH)) : WA'(tsum);
    psum = tsum - (WA+2)'(1);
    wp_prev = (psum >= (WA+2)'(WAYPOINT_DEPTH)) ?
              WA'(psum - (WA+2)'(WAYPOINT_DEPTH)) : WA'(psum);
    top_inc = (top_q == CR_LAST) ? '0 : top_q + CA'(1);
    top_dec = (top_q == '0) ? CR_LAST : top_q - CA'(1);
    tgt = (op_q == OP_CRUMB || !auto_q) ? cr_rdata : wp_rdata;
  end

  // heading error and steering arithmetic
  always_comb begin
    yawv  = (yaw_q >= FULL_CDEG) ? yaw_q - FULL_CDEG : yaw_q;
    ediff = $signed({2'b00, head_q}) - $signed({2'b00, yawv});
    if (ediff < 0) begin
      ediff = ediff + 18'sd36000;
    end
    if (ediff > 18'sd18000) begin
      ediff = ediff - 18'sd36000;
    end
    aerr  = err_q < 0 ? 16'(-err_q) : 16'(err_q);
    sprod = 26'(aerr[15:2]) * 26'd13108;
    sq    = sprod[25:16];
    aprod = prod_q < 0 ? 24'(-prod_q) : 24'(prod_q);
    tprod = 23'(aprod[17:6]) * 23'd2622;
    tq    = tprod[22:16];
    tmag  = (aprod >= 24'd160000) ? 7'd99 : tq;
    steer_w = prod_q < 0 ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
  end

  always_comb begin
    state_d = state_q;
    hd_d = hd_q;
    wcnt_d = wcnt_q;
    top_d = top_q;
    ccnt_d = ccnt_q;
    auto_d = auto_q;
    fs_d = fs_q;
    head_d = head_q;
    ldist_d = ldist_q;
    dlat_d = dlat_q;
    dlon_d = dlon_q;
    err_d = err_q;
    wp_we = 1'b0;
    wp_waddr = wp_tail;
    cr_we = 1'b0;
    wp_raddr = (op_q == OP_ADD) ? wp_prev : hd_q;
    start = 1'b0;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        state_d = S_IDLE;
        case (op_q)
          OP_CTRL: begin
            if (auto_q || fs_q) begin
              state_d = S_FIN;
              if (auto_q ? (wcnt_q != '0) : (ccnt_q != '0)) begin
                if (fresh) begin
                  state_d = S_LOAD;
                end
              end
            end
          end
          OP_CRUMB: begin
            if (!fs_q && in_fence) begin
              if (ccnt_q == '0) begin
                cr_we = 1'b1;
                top_d = top_inc;
                ccnt_d = ccnt_q + CC'(1);
              end else begin
                state_d = S_LOAD;
              end
            end
          end
          OP_ADD: begin
            if (in_fence && wcnt_q != WP_FULL) begin
              if (wcnt_q == '0) begin
                wp_we = 1'b1;
                wcnt_d = wcnt_q + WC'(1);
              end else begin
                state_d = S_ADDCK;
              end
            end
          end
          OP_GO:    auto_d = 1'b1;
          OP_STOP:  auto_d = 1'b0;
          OP_CLEAR: wcnt_d = '0;
          OP_FS_ON: fs_d = 1'b1;
          default:  fs_d = 1'b0;
        endcase
      end
      S_ADDCK: begin
        state_d = S_IDLE;
        if (wp_rdata.lat != lat_q && wp_rdata.lon != lon_q) begin
          wp_we = 1'b1;
          wcnt_d = wcnt_q + WC'(1);
        end
      end
      S_LOAD: begin
        dlat_d = 32'(tgt.lat) - 32'(lat_q);
        dlon_d = 33'(tgt.lon) - 33'(lon_q);
        state_d = S_START;
      end
      S_START: begin
        start = 1'b1;
        state_d = S_CALC;
      end
      S_CALC: begin
        if (dist_vld && cor_vld) begin
          if (op_q == OP_CRUMB) begin
            state_d = S_IDLE;
            if (dist_res > DIST_W'(spacing_q)) begin
              cr_we = 1'b1;
              top_d = top_inc;
              if (ccnt_q != CR_FULL) begin
                ccnt_d = ccnt_q + CC'(1);
              end
            end
          end else begin
            state_d = S_FIN;
            head_d = heading;
            ldist_d = dist_res;
            if (auto_q) begin
              if (dist_res < DIST_W'(rad_auto_q)) begin
                hd_d = (hd_q == WP_LAST) ? '0 : hd_q + WA'(1);
                wcnt_d = wcnt_q - WC'(1);
              end
            end else if (dist_res < DIST_W'(rad_fs_q)) begin
              top_d = top_dec;
              ccnt_d = ccnt_q - CC'(1);
            end
          end
        end
      end
      S_FIN: begin
        if (auto_q) begin
          if (wcnt_q == '0) begin
            auto_d = 1'b0;
          end
        end else if (ccnt_q == '0) begin
          fs_d = 1'b0;
        end
        err_d = ediff[15:0];
        state_d = S_MUL;
      end
      S_MUL: state_d = S_OUT;
      S_OUT: begin
        if (!auto_q && !fs_q) begin
          state_d = S_IDLE;
        end else if (!out_vld_q || out_o.ready) begin
          out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_vld_d = out_load || (out_vld_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      home_lat_q <= HOME_LAT_RST;
      home_lon_q <= HOME_LON_RST;
      fence_q    <= FENCE_RST;
      gain_q     <= GAIN_RST;
      rad_auto_q <= RAD_AUTO_RST;
      rad_fs_q   <= RAD_FS_RST;
      spacing_q  <= SPACING_RST;
      state_q    <= S_IDLE;
      hd_q       <= '0;
      wcnt_q     <= '0;
      top_q      <= '0;
      ccnt_q     <= '0;
      auto_q     <= 1'b0;
      fs_q       <= 1'b0;
      head_q     <= '0;
      ldist_q    <= DIST_RST;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HOME_LAT: home_lat_q <= cfg_wdata_i[LAT_W-1:0];
          CFG_HOME_LON: home_lon_q <= cfg_wdata_i;
          CFG_FENCE:    fence_q    <= cfg_wdata_i[29:0];
          CFG_GAIN:     gain_q     <= cfg_wdata_i[7:0];
          CFG_RAD_AUTO: rad_auto_q <= cfg_wdata_i[16:0];
          CFG_RAD_FS:   rad_fs_q   <= cfg_wdata_i[16:0];
          CFG_SPACING:  spacing_q  <= cfg_wdata_i[19:0];
          default: ;
        endcase
      end
      state_q   <= state_d;
      hd_q      <= hd_d;
      wcnt_q    <= wcnt_d;
      top_q     <= top_d;
      ccnt_q    <= ccnt_d;
      auto_q    <= auto_d;
      fs_q      <= fs_d;
      head_q    <= head_d;
      ldist_q   <= ldist_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_i.valid) begin
      op_q  <= in_i.op;
      lat_q <= in_i.lat;
      lon_q <= in_i.lon;
      yaw_q <= in_i.yaw_cdeg;
      fix_q <= in_i.fix_new;
    end
    dlat_q <= dlat_d;
    dlon_q <= dlon_d;
    err_q  <= err_d;
    prod_q <= $signed({1'b0, gain_q}) * err_q;
    spd_q  <= (sq == '0) ? 7'd99 : ((sq >= 10'd100) ? 7'd0 : 7'(10'd100 - sq));
    if (out_load) begin
      steer_q    <= steer_w;
      speed_q    <= spd_q;
      nav_q      <= !auto_q;
      wl_q       <= LEFT_W'(wcnt_q);
      cl_q       <= LEFT_W'(ccnt_q);
      dist_out_q <= ldist_q;
    end
  end

  wsc_ram #(.Width(POS_W), .Depth(WAYPOINT_DEPTH)) u_wp_ram (
    .clk_i   (clk_i),
    .we_i    (wp_we),
    .waddr_i (wp_waddr),
    .wdata_i (POS_W'(cur)),
    .raddr_i (wp_raddr),
    .rdata_o (wp_rraw)
  );

  wsc_ram #(.Width(POS_W), .Depth(CRUMB_DEPTH)) u_cr_ram (
    .clk_i   (clk_i),
    .we_i    (cr_we),
    .waddr_i (top_inc),
    .wdata_i (POS_W'(cur)),
    .raddr_i (top_q),
    .rdata_o (cr_rraw)
  );

  wsc_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .dlat_i  (dlat_q),
    .dlon_i  (dlon_q),
    .vld_o   (dist_vld),
    .dist_o  (dist_res)
  );

  wsc_cordic u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .dlat_i    (dlat_q),
    .dlon_i    (dlon_q),
    .vld_o     (cor_vld),
    .heading_o (heading)
  );

  assign in_i.ready           = (state_q == S_IDLE);
  assign out_o.valid          = out_vld_q;
  assign out_o.steer          = steer_q;
  assign out_o.speed          = speed_q;
  assign out_o.nav_mode       = nav_q;
  assign out_o.waypoints_left = wl_q;
  assign out_o.crumbs_left    = cl_q;
  assign out_o.distance_cm    = dist_out_q;
endmodule
